[sv/assert_macros.svh]
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/sha_pkg.sv]
// Package with SHA-256 constants, types and round functions
`default_nettype none
package sha_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;

    typedef enum logic [1:0] {
        T_KIND_DATA = 2'd0,
        T_KIND_LAST = 2'd1,
        T_KIND_FLUSH = 2'd2
    } t_kind;

    // One word for the back end: the word itself and what to do after it
    typedef struct packed {
        logic [31:0] word;
        logic        finish;
    } t_qword;

    typedef enum logic [2:0] {
        T_FE_IDLE,
        T_FE_ZERO,
        T_FE_LEN_HI,
        T_FE_LEN_LO
    } t_fe_state;

    typedef enum logic [2:0] {
        T_BE_FILL,
        T_BE_ROUND,
        T_BE_ADD,
        T_BE_EMIT
    } t_be_state;

    typedef logic [7:0][31:0] t_hash;

    localparam t_hash InitH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage
`default_nettype wire

[sv/sha_intf.sv]
// Handshake channel interfaces for message words and digest words
`default_nettype none
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_end;
    modport source (output valid, digest_word, digest_end, input ready);
    modport sink (input valid, digest_word, digest_end, output ready);
endinterface
`default_nettype wire

[sv/sha_front.sv]
// Front end: counts bytes, applies padding and length, feeds the word queue
`default_nettype none
module sha_front
    import sha_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sha_in_if.sink      in_ch,
    output t_qword      o_qword,
    output logic        o_qvalid,
    input  wire logic   i_qready
);

    t_fe_state   r_state, n_state;
    logic [3:0]  r_slot, n_slot;
    logic [60:0] r_total, n_total;
    logic [2:0]  cnt;
    logic [31:0] keep;
    logic [31:0] padw;
    logic [63:0] bits;
    logic        acc;

    always_comb begin
        cnt = (in_ch.byte_count > 3'd4 || !in_ch.last) ? 3'd4 : in_ch.byte_count;
        case (cnt)
            3'd0: keep = 32'h0;
            3'd1: keep = 32'hff00_0000;
            3'd2: keep = 32'hffff_0000;
            3'd3: keep = 32'hffff_ff00;
            default: keep = 32'hffff_ffff;
        endcase
        case (cnt)
            3'd0: padw = 32'h8000_0000;
            3'd1: padw = (in_ch.data_word & keep) | 32'h0080_0000;
            3'd2: padw = (in_ch.data_word & keep) | 32'h0000_8000;
            3'd3: padw = (in_ch.data_word & keep) | 32'h0000_0080;
            default: padw = in_ch.data_word;
        endcase
        bits = {r_total, 3'b000};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_total = r_total;
        acc = in_ch.valid && in_ch.ready;
        case (r_state)
            T_FE_IDLE: begin
                if (acc) begin
                    n_total = r_total + 61'(cnt);
                    n_slot = r_slot + 4'd1;
                    // after the last word come the zero words, led by a marker word if it was full
                    if (in_ch.last) n_state = T_FE_ZERO;
                end
            end
            T_FE_ZERO: if (i_qready) begin
                n_slot = r_slot + 4'd1;
                if (r_slot == 4'd13) n_state = T_FE_LEN_HI;
            end
            T_FE_LEN_HI: if (i_qready) begin
                n_slot = r_slot + 4'd1;
                n_state = T_FE_LEN_LO;
            end
            T_FE_LEN_LO: if (i_qready) begin
                n_slot = 4'd0;
                n_total = '0;
                n_state = T_FE_IDLE;
            end
            default: n_state = T_FE_IDLE;
        endcase
    end

    // Emission of words into the queue
    logic r_mark;  // marker word for a full last word still owed
    logic n_mark;
    always_comb begin
        o_qvalid = 1'b0;
        o_qword  = '0;
        in_ch.ready = 1'b0;
        n_mark = r_mark;
        case (r_state)
            T_FE_IDLE: begin
                in_ch.ready = i_qready;
                o_qvalid = in_ch.valid;
                o_qword.word = (in_ch.last && cnt != 3'd4) ? padw : in_ch.data_word;
                if (acc) n_mark = in_ch.last && (cnt == 3'd4);
            end
            T_FE_ZERO: begin
                o_qvalid = 1'b1;
                o_qword.word = r_mark ? 32'h8000_0000 : 32'h0;
                if (i_qready) n_mark = 1'b0;
            end
            T_FE_LEN_HI: begin
                o_qvalid = 1'b1;
                o_qword.word = bits[63:32];
            end
            T_FE_LEN_LO: begin
                o_qvalid = 1'b1;
                o_qword.word = bits[31:0];
                o_qword.finish = 1'b1;
            end
            default: o_qvalid = 1'b0;
        endcase
    end

    // ZERO state must be skipped straight to length when slot hits 14 and no marker
    t_fe_state f_state;
    always_comb begin
        f_state = n_state;
        if (n_state == T_FE_ZERO && n_slot == 4'd14 && !n_mark) f_state = T_FE_LEN_HI;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_FE_IDLE;
            r_slot  <= '0;
            r_total <= '0;
            r_mark  <= 1'b0;
        end else begin
            r_state <= f_state;
            r_slot  <= n_slot;
            r_total <= n_total;
            r_mark  <= n_mark;
        end
    end

endmodule
`default_nettype wire

[sv/sha_queue.sv]
// Short word queue between front and back end
`default_nettype none
module sha_queue
    import sha_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qword i_wr,
    input  wire logic   i_wvalid,
    output logic        o_wready,
    output t_qword      o_rd,
    output logic        o_rvalid,
    input  wire logic   i_rready
);

    t_qword                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wp, r_rp;
    logic [QueuePtrW:0]     r_cnt;
    logic                   push, pop;

    assign o_wready = (r_cnt != QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
    assign o_rvalid = (r_cnt != '0);
    assign o_rd     = r_mem[r_rp];
    assign push     = i_wvalid && o_wready;
    assign pop      = o_rvalid && i_rready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

[sv/sha_core.sv]
// Back end: block buffer, schedule expansion, 64 rounds, digest output
`default_nettype none
module sha_core
    import sha_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qword i_qword,
    input  wire logic   i_qvalid,
    output logic        o_qready,
    sha_out_if.source   out_ch,
    output t_be_state   o_state
);

    t_be_state   r_state, n_state;
    logic [15:0][31:0] r_w;       // sliding schedule window
    t_hash       r_h, r_v;
    logic [3:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;
    logic        r_fin;
    logic [31:0] wnew, t1, t2;
    logic        take, ofire;

    assign o_state = r_state;

    // Next state
    always_comb begin
        n_state = r_state;
        take = i_qvalid && (r_state == T_BE_FILL);
        ofire = out_ch.valid && out_ch.ready;
        case (r_state)
            T_BE_FILL:  if (take && r_fill == 4'd15) n_state = T_BE_ROUND;
            T_BE_ROUND: if (r_rnd == 6'd63) n_state = T_BE_ADD;
            T_BE_ADD:   n_state = r_fin ? T_BE_EMIT : T_BE_FILL;
            T_BE_EMIT:  if (ofire && r_oidx == 3'd7) n_state = T_BE_FILL;
            default:    n_state = T_BE_FILL;
        endcase
    end

    // Outputs
    always_comb begin
        o_qready = (r_state == T_BE_FILL);
        out_ch.valid = (r_state == T_BE_EMIT);
        out_ch.digest_word = r_h[r_oidx];
        out_ch.digest_end = (r_oidx == 3'd7);
    end

    always_comb begin
        wnew = r_w[0] + sig0(r_w[1]) + r_w[9] + sig1(r_w[14]);
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + round_k(r_rnd) + r_w[0];
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_w <= {i_qword.word, r_w[15:1]};
        end else if (r_state == T_BE_ROUND) begin
            r_w <= {wnew, r_w[15:1]};
        end
        if (take && r_fill == 4'd15) r_v <= r_h;
        else if (r_state == T_BE_ROUND)
            r_v <= {r_v[6:4], r_v[3] + t1, r_v[2:0], t1 + t2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_BE_FILL;
            r_h <= InitH;
            r_fill <= '0;
            r_rnd <= '0;
            r_oidx <= '0;
            r_fin <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_fill <= r_fill + 4'd1;
                r_fin <= i_qword.finish;
            end
            if (r_state == T_BE_ROUND) r_rnd <= r_rnd + 6'd1;
            if (r_state == T_BE_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (ofire) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) r_h <= InitH;
            end
        end
    end

endmodule
`default_nettype wire

[sv/sha256_digest.sv]
// Top level of the SHA-256 digest engine
//  Channel   Dir  Payload                        Beat rule
//  in_ch     in   data_word, byte_count, last    valid & ready
//  out_ch    out  digest_word, digest_end        valid & ready
//  Each 16-word block is filled, then run through the rounds and added, using
//  the single shared round unit; queue words are taken only while filling.
//  Padding adds up to 18 queue words after the last beat; 8 output beats follow.
//  Synchronous active-low reset returns hash state to the initial values.
//  Input stalls while the word queue is full; output stalls hold the digest.
`default_nettype none
`include "assert_macros.svh"
module sha256_digest
    import sha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    t_qword    fw, qw;
    logic      fv, fr, qv, qr;
    t_be_state be_state;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_qword(fw), .o_qvalid(fv), .i_qready(fr));

    sha_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(fw), .i_wvalid(fv), .o_wready(fr),
        .o_rd(qw), .o_rvalid(qv), .i_rready(qr));

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_qword(qw), .i_qvalid(qv), .o_qready(qr),
        .out_ch(out_ch), .o_state(be_state));

    `CHK_IMPL(a_out_only_emit, i_clk, i_rst_n, out_ch.valid, be_state == T_BE_EMIT)
    `CHK_NEXT(a_round_no_take, i_clk, i_rst_n, be_state == T_BE_ROUND, !qr)

endmodule
`default_nettype wire

[tb/sv/sha256_digest_chk.sv]
// Checker that predicts SHA-256 digests from input beats and compares output beats
`timescale 1ns / 100ps
`default_nettype none
module sha256_digest_chk
    import sha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    in_mon,
    sha_out_if.sink   out_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_end;
    } t_digest_beat;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0]  hash_state [8];
    logic [31:0]  block_buf [16];
    logic [3:0]   fill_slot;
    logic [60:0]  byte_total;
    t_digest_beat digest_queue [$];

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic clear_hash();
        hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        fill_slot  = '0;
        byte_total = '0;
    endtask

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + RoundK[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic push_block_word(input logic [31:0] word);
        block_buf[fill_slot] = word;
        fill_slot++;
        if (fill_slot == 0) compress();
    endtask

    task automatic absorb_beat(input logic [31:0] data, input logic [2:0] cnt, input logic lst);
        int          nbytes;
        logic [31:0] pad_word;
        logic [63:0] bit_len;
        nbytes = (!lst || cnt > 4) ? 4 : int'(cnt);
        byte_total = byte_total + 61'(nbytes);
        if (!lst) begin
            push_block_word(data);
            return;
        end
        if (nbytes == 4) begin
            push_block_word(data);
            pad_word = 32'h8000_0000;
        end else begin
            pad_word = (nbytes == 0) ? 32'h0 : (data & (32'hffff_ffff << (32 - 8 * nbytes)));
            pad_word |= 32'h80 << (24 - 8 * nbytes);
        end
        push_block_word(pad_word);
        if (fill_slot > 14) while (fill_slot != 0) push_block_word('0);
        while (fill_slot != 14) push_block_word('0);
        bit_len = {byte_total, 3'b000};
        push_block_word(bit_len[63:32]);
        push_block_word(bit_len[31:0]);
        for (int i = 0; i < 8; i++) digest_queue.push_back('{hash_state[i], i == 7});
        clear_hash();
    endtask

    assign o_pending = digest_queue.size();

    initial begin
        o_fail_count = 0;
        clear_hash();
    end

    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n) begin
            if (in_mon.valid && in_mon.ready)
                absorb_beat(in_mon.data_word, in_mon.byte_count, in_mon.last);
            if (out_mon.valid && out_mon.ready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest beat %h", out_mon.digest_word);
                    o_fail_count++;
                end else begin
                    exp_beat = digest_queue.pop_front();
                    if (out_mon.digest_word !== exp_beat.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               exp_beat.digest_word, out_mon.digest_word);
                        o_fail_count++;
                    end
                    if (out_mon.digest_end !== exp_beat.digest_end) begin
                        $error("digest_end expected %b actual %b",
                               exp_beat.digest_end, out_mon.digest_end);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[tb/sv/sha256_digest_tb.sv]
// Testbench top: drives message beats and random output stalls, gives the verdict
`timescale 1ns / 100ps
`default_nettype none
module sha256_digest_tb;
    import sha_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   words_sent = 0;
    bit   out_long_stall = 1'b0;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_digest u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    sha256_digest_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_ch.sink),
        .out_mon     (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random receiver stalls: mostly short, some long
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (out_long_stall) out_ch.ready <= (r < 5);
        else out_ch.ready <= (r < 70);
        if (r == 99) out_long_stall <= ~out_long_stall;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one beat and hold it until accepted
    task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic lst,
                             input bit may_idle);
        int gap;
        gap = may_idle ? gap_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_word  <= data;
        in_ch.byte_count <= cnt;
        in_ch.last       <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_message(input int nwords, input logic [2:0] tail_cnt,
                                input bit may_idle);
        for (int i = 0; i < nwords; i++)
            send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0, may_idle);
        send_word($urandom(), tail_cnt, 1'b1, may_idle);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int nw;
        in_ch.valid      = 1'b0;
        in_ch.data_word  = '0;
        in_ch.byte_count = '0;
        in_ch.last       = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, all-ones and all-zeros words, each tail count,
        // oversize counts, and padding right at the block boundary
        send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b0);
        send_word(32'hffff_ffff, 3'd7, 1'b1, 1'b0);
        send_word(32'h0000_0000, 3'd4, 1'b1, 1'b0);
        send_word(32'h0000_0000, 3'd1, 1'b0, 1'b0);
        send_word(32'hffff_ffff, 3'd1, 1'b1, 1'b0);
        send_word(32'h6162_6300, 3'd3, 1'b1, 1'b0);
        send_word(32'hffff_ffff, 3'd2, 1'b1, 1'b0);
        send_word(32'haaaa_aaaa, 3'd5, 1'b1, 1'b0);
        send_message(13, 3'd4, 1'b0);
        drain();
        send_message(14, 3'd3, 1'b0);

        // Hold off until every digest has come out
        drain();

        // Random messages: mostly short, a few spanning several blocks
        while (words_sent < 300) begin
            nw = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
            send_message(nw, 3'($urandom_range(0, 7)), 1'b1);
            if ($urandom_range(0, 9) == 0) drain();
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/sha_pkg.sv
sv/sha_intf.sv
sv/sha_front.sv
sv/sha_queue.sv
sv/sha_core.sv
sv/sha256_digest.sv
tb/sv/sha256_digest_chk.sv
tb/sv/sha256_digest_tb.sv
